// File: hw/rtl/stc_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the segment triangle crossing pipeline
package stc_pkg;

   localparam int LANE_BITS      = 16;
   localparam int COORD_BITS     = 16;
   localparam int LANES          = 3;
   localparam int POINTS         = 5;
   localparam int REQ_DATA_BITS  = POINTS * LANES * LANE_BITS;
   localparam int REQ_USER_BITS  = 2;
   localparam int RSP_DATA_BITS  = 8;

   typedef enum logic [1:0] {
      AXIS_NONE = 2'd0,
      AXIS_X    = 2'd1,
      AXIS_Y    = 2'd2,
      AXIS_Z    = 2'd3
   } axis_type;

endpackage

// File: hw/rtl/stc_front.sv
`timescale 1ns / 1ps
// first stage: lane unpacking, edge vectors, offsets and projected edge terms
module stc_front #(
   parameter int COORD_BITS = stc_pkg::COORD_BITS,
   localparam int EB = (COORD_BITS < stc_pkg::LANE_BITS) ? COORD_BITS : stc_pkg::LANE_BITS,
   localparam int DB = EB + 1,
   localparam int WB = stc_pkg::LANES * stc_pkg::LANE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [WB-1:0]        vertex_a,
   input  logic [WB-1:0]        vertex_b,
   input  logic [WB-1:0]        vertex_c,
   input  logic [WB-1:0]        start_point,
   input  logic [WB-1:0]        end_point,
   input  stc_pkg::axis_type    axis,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [DB-1:0] ab_out [3],
   output logic signed [DB-1:0] cb_out [3],
   output logic signed [DB-1:0] sa_out [3],
   output logic signed [DB-1:0] ea_out [3],
   output logic signed [DB-1:0] eu_out [3],
   output logic signed [DB-1:0] ew_out [3],
   output logic signed [DB-1:0] du_out [3],
   output logic signed [DB-1:0] dw_out [3],
   output logic                 axis_ok_out
);

   localparam int LB = stc_pkg::LANE_BITS;

   logic signed [EB-1:0] va [3];
   logic signed [EB-1:0] vb [3];
   logic signed [EB-1:0] vc [3];
   logic signed [EB-1:0] sp [3];
   logic signed [EB-1:0] ep [3];
   logic signed [EB-1:0] pu [3];
   logic signed [EB-1:0] pw [3];
   logic signed [EB-1:0] su;
   logic signed [EB-1:0] sw;

   logic signed [DB-1:0] ab_in [3];
   logic signed [DB-1:0] cb_in [3];
   logic signed [DB-1:0] sa_in [3];
   logic signed [DB-1:0] ea_in [3];
   logic signed [DB-1:0] eu_in [3];
   logic signed [DB-1:0] ew_in [3];
   logic signed [DB-1:0] du_in [3];
   logic signed [DB-1:0] dw_in [3];

   logic signed [DB-1:0] ab_ff [3];
   logic signed [DB-1:0] cb_ff [3];
   logic signed [DB-1:0] sa_ff [3];
   logic signed [DB-1:0] ea_ff [3];
   logic signed [DB-1:0] eu_ff [3];
   logic signed [DB-1:0] ew_ff [3];
   logic signed [DB-1:0] du_ff [3];
   logic signed [DB-1:0] dw_ff [3];
   logic                 axis_ok_ff;
   logic                 valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         va[i] = vertex_a[i*LB +: EB];
         vb[i] = vertex_b[i*LB +: EB];
         vc[i] = vertex_c[i*LB +: EB];
         sp[i] = start_point[i*LB +: EB];
         ep[i] = end_point[i*LB +: EB];
      end
   end

   // projected plane: (y,z) for x, (z,x) for y, (x,y) for z
   always_comb begin
      case (axis)
         stc_pkg::AXIS_X: begin
            pu[0] = va[1]; pu[1] = vb[1]; pu[2] = vc[1]; su = sp[1];
            pw[0] = va[2]; pw[1] = vb[2]; pw[2] = vc[2]; sw = sp[2];
         end
         stc_pkg::AXIS_Y: begin
            pu[0] = va[2]; pu[1] = vb[2]; pu[2] = vc[2]; su = sp[2];
            pw[0] = va[0]; pw[1] = vb[0]; pw[2] = vc[0]; sw = sp[0];
         end
         default: begin
            pu[0] = va[0]; pu[1] = vb[0]; pu[2] = vc[0]; su = sp[0];
            pw[0] = va[1]; pw[1] = vb[1]; pw[2] = vc[1]; sw = sp[1];
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ab_in[i] = {va[i][EB-1], va[i]} - {vb[i][EB-1], vb[i]};
         cb_in[i] = {vc[i][EB-1], vc[i]} - {vb[i][EB-1], vb[i]};
         sa_in[i] = {sp[i][EB-1], sp[i]} - {va[i][EB-1], va[i]};
         ea_in[i] = {ep[i][EB-1], ep[i]} - {va[i][EB-1], va[i]};
         eu_in[i] = {pu[(i+1)%3][EB-1], pu[(i+1)%3]} - {pu[i][EB-1], pu[i]};
         ew_in[i] = {pw[(i+1)%3][EB-1], pw[(i+1)%3]} - {pw[i][EB-1], pw[i]};
         du_in[i] = {pu[i][EB-1], pu[i]} - {su[EB-1], su};
         dw_in[i] = {pw[i][EB-1], pw[i]} - {sw[EB-1], sw};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ab_ff      <= ab_in;
         cb_ff      <= cb_in;
         sa_ff      <= sa_in;
         ea_ff      <= ea_in;
         eu_ff      <= eu_in;
         ew_ff      <= ew_in;
         du_ff      <= du_in;
         dw_ff      <= dw_in;
         axis_ok_ff <= (axis != stc_pkg::AXIS_NONE);
      end
   end

   assign out_valid   = valid_ff;
   assign ab_out      = ab_ff;
   assign cb_out      = cb_ff;
   assign sa_out      = sa_ff;
   assign ea_out      = ea_ff;
   assign eu_out      = eu_ff;
   assign ew_out      = ew_ff;
   assign du_out      = du_ff;
   assign dw_out      = dw_ff;
   assign axis_ok_out = axis_ok_ff;

endmodule

// File: hw/rtl/stc_cross.sv
`timescale 1ns / 1ps
// two stages: cross product terms, then triangle normal and edge sign agreement
module stc_cross #(
   parameter int COORD_BITS = stc_pkg::COORD_BITS,
   localparam int EB = (COORD_BITS < stc_pkg::LANE_BITS) ? COORD_BITS : stc_pkg::LANE_BITS,
   localparam int DB = EB + 1,
   localparam int PB = 2 * DB,
   localparam int NB = PB + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [DB-1:0] ab_in [3],
   input  logic signed [DB-1:0] cb_in [3],
   input  logic signed [DB-1:0] sa_in [3],
   input  logic signed [DB-1:0] ea_in [3],
   input  logic signed [DB-1:0] eu_in [3],
   input  logic signed [DB-1:0] ew_in [3],
   input  logic signed [DB-1:0] du_in [3],
   input  logic signed [DB-1:0] dw_in [3],
   input  logic                 axis_ok_in,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [NB-1:0] nrm_out [3],
   output logic signed [DB-1:0] sa_out [3],
   output logic signed [DB-1:0] ea_out [3],
   output logic                 gate_out
);

   logic                 prod_ready;
   logic                 prod_valid_ff;
   logic signed [PB-1:0] np_pos_ff [3];
   logic signed [PB-1:0] np_neg_ff [3];
   logic signed [PB-1:0] ep_pos_ff [3];
   logic signed [PB-1:0] ep_neg_ff [3];
   logic signed [DB-1:0] sa_p_ff [3];
   logic signed [DB-1:0] ea_p_ff [3];
   logic                 axis_ok_p_ff;

   logic signed [NB-1:0] nrm_in [3];
   logic signed [NB-1:0] edge_val [3];
   logic                 pos [3];
   logic                 neg [3];
   logic                 gate_in;

   logic                 sum_valid_ff;
   logic signed [NB-1:0] nrm_ff [3];
   logic signed [DB-1:0] sa_s_ff [3];
   logic signed [DB-1:0] ea_s_ff [3];
   logic                 gate_ff;

   assign in_ready   = !prod_valid_ff || prod_ready;
   assign prod_ready = !sum_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (prod_ready) begin
            sum_valid_ff <= prod_valid_ff;
         end
      end
   end

   // normal = (a - b) x (c - b), each part as a pair of products
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         np_pos_ff[0] <= ab_in[1] * cb_in[2];
         np_neg_ff[0] <= ab_in[2] * cb_in[1];
         np_pos_ff[1] <= ab_in[2] * cb_in[0];
         np_neg_ff[1] <= ab_in[0] * cb_in[2];
         np_pos_ff[2] <= ab_in[0] * cb_in[1];
         np_neg_ff[2] <= ab_in[1] * cb_in[0];
         for (int i = 0; i < 3; i++) begin
            ep_pos_ff[i] <= ew_in[i] * du_in[i];
            ep_neg_ff[i] <= eu_in[i] * dw_in[i];
         end
         sa_p_ff      <= sa_in;
         ea_p_ff      <= ea_in;
         axis_ok_p_ff <= axis_ok_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm_in[i]   = {np_pos_ff[i][PB-1], np_pos_ff[i]} - {np_neg_ff[i][PB-1], np_neg_ff[i]};
         edge_val[i] = {ep_pos_ff[i][PB-1], ep_pos_ff[i]} - {ep_neg_ff[i][PB-1], ep_neg_ff[i]};
         neg[i]      = edge_val[i][NB-1];
         pos[i]      = !edge_val[i][NB-1] && (edge_val[i] != '0);
      end
      // zero agrees with either sign, checked pairwise against the middle edge
      gate_in = axis_ok_p_ff
              && !((pos[0] && neg[1]) || (neg[0] && pos[1]))
              && !((pos[1] && neg[2]) || (neg[1] && pos[2]));
   end

   always_ff @(posedge clock) begin
      if (prod_ready && prod_valid_ff) begin
         nrm_ff  <= nrm_in;
         sa_s_ff <= sa_p_ff;
         ea_s_ff <= ea_p_ff;
         gate_ff <= gate_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign nrm_out   = nrm_ff;
   assign sa_out    = sa_s_ff;
   assign ea_out    = ea_s_ff;
   assign gate_out  = gate_ff;

endmodule

// File: hw/rtl/stc_side.sv
`timescale 1ns / 1ps
// two stages: plane side products, then side sums and the crossing decision
module stc_side #(
   parameter int COORD_BITS = stc_pkg::COORD_BITS,
   localparam int EB = (COORD_BITS < stc_pkg::LANE_BITS) ? COORD_BITS : stc_pkg::LANE_BITS,
   localparam int DB = EB + 1,
   localparam int NB = 2 * DB + 1,
   localparam int MB = NB + DB,
   localparam int QB = MB + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [NB-1:0] nrm_in [3],
   input  logic signed [DB-1:0] sa_in [3],
   input  logic signed [DB-1:0] ea_in [3],
   input  logic                 gate_in,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 crosses
);

   logic                 prod_ready;
   logic                 prod_valid_ff;
   logic signed [MB-1:0] ps_ff [3];
   logic signed [MB-1:0] pe_ff [3];
   logic                 flip_ff;
   logic                 gate_p_ff;

   logic signed [QB-1:0] xs;
   logic signed [QB-1:0] xe;
   logic                 s_ge;
   logic                 e_ge;
   logic                 crosses_in;

   logic                 valid_ff;
   logic                 crosses_ff;

   assign in_ready   = !prod_valid_ff || prod_ready;
   assign prod_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         if (in_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (prod_ready) begin
            valid_ff <= prod_valid_ff;
         end
      end
   end

   // n.(p - a) for both end points, raw normal; the z flip is applied to the sign
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         for (int i = 0; i < 3; i++) begin
            ps_ff[i] <= nrm_in[i] * sa_in[i];
            pe_ff[i] <= nrm_in[i] * ea_in[i];
         end
         flip_ff   <= nrm_in[2][NB-1];
         gate_p_ff <= gate_in;
      end
   end

   always_comb begin
      xs = QB'(ps_ff[0]) + QB'(ps_ff[1]) + QB'(ps_ff[2]);
      xe = QB'(pe_ff[0]) + QB'(pe_ff[1]) + QB'(pe_ff[2]);
      s_ge = flip_ff ? (xs[QB-1] || (xs == '0)) : !xs[QB-1];
      e_ge = flip_ff ? (xe[QB-1] || (xe == '0)) : !xe[QB-1];
      crosses_in = gate_p_ff && (s_ge != e_ge);
   end

   always_ff @(posedge clock) begin
      if (prod_ready && prod_valid_ff) begin
         crosses_ff <= crosses_in;
      end
   end

   assign out_valid = valid_ff;
   assign crosses   = crosses_ff;

endmodule

// File: hw/rtl/axis_segment_triangle_cross.sv
`timescale 1ns / 1ps
// top level of the axis-parallel segment versus triangle crossing test
//
// Each item carries a triangle, a segment start and end point and the segment
// axis; one result item with the crossing flag comes back per item. The block
// is a five-register pipeline (unpack and differences, cross product terms,
// normal and edge signs, plane side products, side sums and decision), so a
// new item is taken every clock cycle when the output side does not stall.
// Every stage has its own valid bit and ready, so empty stages fill while
// the output waits. The longest path is one signed multiply of about 35 by
// 17 bits in the side product stage. Coordinates are the sign-extended low
// COORD_BITS bits of each 16-bit lane.
module axis_segment_triangle_cross #(
   parameter int COORD_BITS = stc_pkg::COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // vertex_a, vertex_b, vertex_c, start_point, end_point
   input  logic [stc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // axis
   input  logic [stc_pkg::REQ_USER_BITS-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // crosses, zero padding
   output logic [stc_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int EB = (COORD_BITS < stc_pkg::LANE_BITS) ? COORD_BITS : stc_pkg::LANE_BITS;
   localparam int DB = EB + 1;
   localparam int NB = 2 * DB + 1;
   localparam int WB = stc_pkg::LANES * stc_pkg::LANE_BITS;

   logic                 f_valid;
   logic                 f_ready;
   logic signed [DB-1:0] ab [3];
   logic signed [DB-1:0] cb [3];
   logic signed [DB-1:0] f_sa [3];
   logic signed [DB-1:0] f_ea [3];
   logic signed [DB-1:0] eu [3];
   logic signed [DB-1:0] ew [3];
   logic signed [DB-1:0] du [3];
   logic signed [DB-1:0] dw [3];
   logic                 axis_ok;

   logic                 c_valid;
   logic                 c_ready;
   logic signed [NB-1:0] nrm [3];
   logic signed [DB-1:0] c_sa [3];
   logic signed [DB-1:0] c_ea [3];
   logic                 gate;

   logic                 crosses;

   stc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .vertex_a    (req_tdata[0*WB +: WB]),
      .vertex_b    (req_tdata[1*WB +: WB]),
      .vertex_c    (req_tdata[2*WB +: WB]),
      .start_point (req_tdata[3*WB +: WB]),
      .end_point   (req_tdata[4*WB +: WB]),
      .axis        (stc_pkg::axis_type'(req_tuser)),
      .out_valid   (f_valid),
      .out_ready   (f_ready),
      .ab_out      (ab),
      .cb_out      (cb),
      .sa_out      (f_sa),
      .ea_out      (f_ea),
      .eu_out      (eu),
      .ew_out      (ew),
      .du_out      (du),
      .dw_out      (dw),
      .axis_ok_out (axis_ok)
   );

   stc_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid),
      .in_ready   (f_ready),
      .ab_in      (ab),
      .cb_in      (cb),
      .sa_in      (f_sa),
      .ea_in      (f_ea),
      .eu_in      (eu),
      .ew_in      (ew),
      .du_in      (du),
      .dw_in      (dw),
      .axis_ok_in (axis_ok),
      .out_valid  (c_valid),
      .out_ready  (c_ready),
      .nrm_out    (nrm),
      .sa_out     (c_sa),
      .ea_out     (c_ea),
      .gate_out   (gate)
   );

   stc_side #(.COORD_BITS(COORD_BITS)) u_side (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_ready  (c_ready),
      .nrm_in    (nrm),
      .sa_in     (c_sa),
      .ea_in     (c_ea),
      .gate_in   (gate),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .crosses   (crosses)
   );

   assign rsp_tdata = {{(stc_pkg::RSP_DATA_BITS-1){1'b0}}, crosses};

   // an empty output stage lets the whole chain move
   a_ready_when_out_empty: assert property (
      @(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage empty");

   a_no_result_after_reset: assert property (
      @(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_first_stage_moves: assert property (
      @(posedge clock) disable iff (reset) (!f_valid || c_ready) |-> req_tready)
      else $error("front stage stalled with room downstream");

   a_mid_stage_moves: assert property (
      @(posedge clock) disable iff (reset) !rsp_tvalid |-> (c_ready && f_ready))
      else $error("middle stages stalled while output stage empty");

endmodule
